>>> rtl/core/vls_pkg.sv
// ----------------------------------------------------------------------------
// vls_pkg
// Shared types and constants of the vector line sampler.
// ----------------------------------------------------------------------------
package vls_pkg;

	// vertex table
	localparam int VERTEX_COUNT = 64;
	localparam int IDX_W        = $clog2(VERTEX_COUNT);
	localparam int COORD_W      = 16;
	localparam int FRAC_BITS    = 14;

	// samples per line
	localparam int MAX_LINE_SAMPLES = 64;
	localparam int CNT_W            = 7;
	localparam int STEP_W           = 6;
	localparam int SCALE_W          = 15;

	// divider: one quotient bit per cycle over the delta magnitude
	localparam int DIV_STEPS = COORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd2;

	// reset values of the registers
	localparam logic [CNT_W-1:0]   SAMPLES_RESET = 7'd64;
	localparam logic [SCALE_W-1:0] SCALE_X_RESET = 15'd30000;
	localparam logic [SCALE_W-1:0] SCALE_Y_RESET = 15'd16000;

	// one queued line: both end points
	typedef struct packed {
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
	} line_t;

	// register settings seen by the back end
	typedef struct packed {
		logic [CNT_W-1:0]   samples;
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
	} cfg_t;

	// back end sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN
	} back_state_t;

endpackage

>>> rtl/core/vls_in_if.sv
// ----------------------------------------------------------------------------
// vls_in_if
// Item channel: vertex writes and line draws.
// ----------------------------------------------------------------------------
interface vls_in_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      operation;
	logic [vls_pkg::IDX_W-1:0]                 vertex_index;
	logic signed [vls_pkg::COORD_W-1:0]        vertex_x;
	logic signed [vls_pkg::COORD_W-1:0]        vertex_y;
	logic [vls_pkg::IDX_W-1:0]                 start_index;
	logic [vls_pkg::IDX_W-1:0]                 end_index;

	modport source (
		output valid, operation, vertex_index, vertex_x, vertex_y, start_index, end_index,
		input  ready
	);
	modport sink (
		input  valid, operation, vertex_index, vertex_x, vertex_y, start_index, end_index,
		output ready
	);
endinterface

>>> rtl/core/vls_out_if.sv
// ----------------------------------------------------------------------------
// vls_out_if
// Sample channel: scaled x/y pair and end-of-line flag.
// ----------------------------------------------------------------------------
interface vls_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [vls_pkg::COORD_W-1:0] scaled_x;
	logic signed [vls_pkg::COORD_W-1:0] scaled_y;
	logic                               last_sample;

	modport source (
		output valid, scaled_x, scaled_y, last_sample,
		input  ready
	);
	modport sink (
		input  valid, scaled_x, scaled_y, last_sample,
		output ready
	);
endinterface

>>> rtl/core/vector_line_sampler_unit.sv
// ----------------------------------------------------------------------------
// vector_line_sampler_unit
// Vertex table and line sampler for an x/y vector display: draws lines
// between stored Q2.14 vertices as scaled, saturated stereo samples.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      word
//  items     in    valid/ready    operation, vertex fields, line end points
//  samples   out   valid/ready    scaled_x, scaled_y, last_sample
//  cfg       in    cfg_we         cfg_index, cfg_data (no read-back)
//
//  A draw in the back end loads the line, divides both deltas bit-serially
//  by n (n = samples per line), then sends one sample per cycle unless the
//  output stalls, through point, product and saturation registers.
//  A two-line queue lets the front keep taking items while a line is drawn.
//  Reset clears control state and the registers; the vertex table is not
//  cleared. A stalled output holds the whole sample pipeline.
// ----------------------------------------------------------------------------
module vector_line_sampler_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	vls_in_if.sink                            items,
	vls_out_if.source                         samples,
	input  logic                              cfg_we,
	input  logic [vls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vls_pkg::SCALE_W-1:0]       cfg_data
);

	vls_pkg::cfg_t  cfg_q;
	vls_pkg::line_t push_line;
	vls_pkg::line_t pop_line;
	logic           push;
	logic           push_ready;
	logic           pop;
	logic           pop_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples <= vls_pkg::SAMPLES_RESET;
			cfg_q.scale_x <= vls_pkg::SCALE_X_RESET;
			cfg_q.scale_y <= vls_pkg::SCALE_Y_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vls_pkg::CFG_SAMPLES: cfg_q.samples <= cfg_data[vls_pkg::CNT_W-1:0];
				vls_pkg::CFG_SCALE_X: cfg_q.scale_x <= cfg_data;
				vls_pkg::CFG_SCALE_Y: cfg_q.scale_y <= cfg_data;
				default: ;
			endcase
		end
	end

	vls_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push       (push),
		.push_line  (push_line),
		.push_ready (push_ready)
	);

	vls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_line  (push_line),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_line   (pop_line),
		.pop_valid  (pop_valid)
	);

	vls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.line_valid (pop_valid),
		.line       (pop_line),
		.pop        (pop),
		.samples    (samples)
	);

endmodule

>>> rtl/core/vls_front.sv
// ----------------------------------------------------------------------------
// vls_front
// Takes items, writes vertices into the table and looks up both end points
// of each draw, handing the line on to the queue.
// ----------------------------------------------------------------------------
module vls_front (
	input  logic               clk,
	input  logic               arst_n,
	vls_in_if.sink             items,
	output logic               push,
	output vls_pkg::line_t     push_line,
	input  logic               push_ready
);

	logic [2*vls_pkg::COORD_W-1:0] mem [vls_pkg::VERTEX_COUNT];
	logic [2*vls_pkg::COORD_W-1:0] rd_a_s1;
	logic [2*vls_pkg::COORD_W-1:0] rd_b_s1;
	logic                          pend_q;
	logic                          acc;
	logic                          acc_draw;

	// handshake: a looked-up line waits until the queue takes it
	assign items.ready = !pend_q || push_ready;
	assign acc         = items.valid && items.ready;
	assign acc_draw    = acc && (items.operation == vls_pkg::OP_DRAW);
	assign push        = pend_q;

	// vertex table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (acc && (items.operation == vls_pkg::OP_WRITE)) begin
			mem[items.vertex_index] <= {items.vertex_x, items.vertex_y};
		end
		if (acc_draw) begin
			rd_a_s1 <= mem[items.start_index];
			rd_b_s1 <= mem[items.end_index];
		end
	end

	// pending line flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (acc_draw) begin
			pend_q <= 1'b1;
		end else if (push_ready) begin
			pend_q <= 1'b0;
		end
	end

	// line word for the queue
	assign push_line.x1 = rd_a_s1[2*vls_pkg::COORD_W-1:vls_pkg::COORD_W];
	assign push_line.y1 = rd_a_s1[vls_pkg::COORD_W-1:0];
	assign push_line.x2 = rd_b_s1[2*vls_pkg::COORD_W-1:vls_pkg::COORD_W];
	assign push_line.y2 = rd_b_s1[vls_pkg::COORD_W-1:0];

	// a draw accepted always leaves a pending line
	a_draw_pends: assert property (@(posedge clk) disable iff (!arst_n)
		acc_draw |=> pend_q)
		else $error("draw accepted without a pending line");

	// the front never stalls while nothing is pending
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_q |-> items.ready)
		else $error("front stalled with nothing pending");

	// a pending line not taken stays pending
	a_pend_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !push_ready |=> pend_q)
		else $error("pending line dropped");

endmodule

>>> rtl/core/vls_queue.sv
// ----------------------------------------------------------------------------
// vls_queue
// Two-entry line queue between the front and the back end.
// ----------------------------------------------------------------------------
module vls_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vls_pkg::line_t push_line,
	output logic           push_ready,
	input  logic           pop,
	output vls_pkg::line_t pop_line,
	output logic           pop_valid
);

	vls_pkg::line_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_line   = ent_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_line;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// fill count agrees with the pointers
	a_cnt_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("queue count and pointers disagree");

	// never over two entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue overfilled");

	// a push into a full queue with no pop leaves it full
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready && !pop |=> !push_ready)
		else $error("full queue lost an entry");

endmodule

>>> rtl/core/vls_back.sv
// ----------------------------------------------------------------------------
// vls_back
// Draws one line: divides each delta by the sample count, then steps the
// quotient and remainder per sample, scales, saturates and sends samples.
// ----------------------------------------------------------------------------
module vls_back (
	input  logic           clk,
	input  logic           arst_n,
	input  vls_pkg::cfg_t  cfg,
	input  logic           line_valid,
	input  vls_pkg::line_t line,
	output logic           pop,
	vls_out_if.source      samples
);

	localparam int W = vls_pkg::COORD_W;

	vls_pkg::back_state_t state_q;
	vls_pkg::back_state_t state_d;

	logic                 div_step;
	logic                 run_step;
	logic                 load;

	// line registers
	logic signed [W-1:0]  p1x_q, p1y_q;
	logic                 negx_q, negy_q;
	logic [W-1:0]         dqx_q, dqy_q;
	logic [vls_pkg::CNT_W-1:0] drx_q, dry_q;
	logic [W-1:0]         accx_q, accy_q;
	logic [vls_pkg::CNT_W-1:0] racx_q, racy_q;
	logic [vls_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [vls_pkg::STEP_W-1:0]    step_q;

	// pipeline
	logic                 en;
	logic                 v_s1;
	logic signed [W-1:0]  vx_s1, vy_s1;
	logic                 last_s1;
	logic                 v_s2;
	logic signed [2*W-1:0] px_s2, py_s2;
	logic                 last_s2;
	logic                 out_valid_q;
	logic signed [W-1:0]  out_x_q, out_y_q;
	logic                 out_last_q;

	// combinational helpers
	logic [vls_pkg::CNT_W-1:0] n;
	logic signed [W:0]    dx, dy;
	logic [W:0]           mag_x, mag_y;
	logic [vls_pkg::CNT_W:0]   remt_x, remt_y;
	logic                 qb_x, qb_y;
	logic [vls_pkg::CNT_W:0]   rsum_x, rsum_y;
	logic                 cy_x, cy_y;
	logic signed [W:0]    offx, offy;
	logic signed [W+1:0]  sumx, sumy;
	logic                 is_last;

	// arithmetic shift by the fraction bits, then clamp to 16 bits
	function automatic logic signed [W-1:0] sat16(input logic signed [2*W-1:0] p);
		logic [2*W-vls_pkg::FRAC_BITS-1:0] sh;
		sh = p[2*W-1:vls_pkg::FRAC_BITS];
		if (sh[2*W-vls_pkg::FRAC_BITS-1:W-1] == '0 ||
		    sh[2*W-vls_pkg::FRAC_BITS-1:W-1] == '1) begin
			sat16 = sh[W-1:0];
		end else if (sh[2*W-vls_pkg::FRAC_BITS-1]) begin
			sat16 = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat16 = {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	// sample count clamped to 1 .. MAX_LINE_SAMPLES
	always_comb begin
		priority if (cfg.samples == '0) begin
			n = vls_pkg::CNT_W'(1);
		end else if (cfg.samples > vls_pkg::CNT_W'(vls_pkg::MAX_LINE_SAMPLES)) begin
			n = vls_pkg::CNT_W'(vls_pkg::MAX_LINE_SAMPLES);
		end else begin
			n = cfg.samples;
		end
	end

	assign en      = !out_valid_q || samples.ready;
	assign is_last = ({1'b0, step_q} == (n - vls_pkg::CNT_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vls_pkg::ST_IDLE: if (line_valid) begin
				state_d = vls_pkg::ST_DIV;
			end
			vls_pkg::ST_DIV: if (div_cnt_q == vls_pkg::DIV_CNT_W'(vls_pkg::DIV_STEPS - 1)) begin
				state_d = vls_pkg::ST_RUN;
			end
			vls_pkg::ST_RUN: if (en && is_last) begin
				state_d = vls_pkg::ST_IDLE;
			end
			default: state_d = vls_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		load     = 1'b0;
		div_step = 1'b0;
		run_step = 1'b0;
		unique case (state_q)
			vls_pkg::ST_IDLE: load     = line_valid;
			vls_pkg::ST_DIV:  div_step = 1'b1;
			vls_pkg::ST_RUN:  run_step = en;
			default: ;
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// deltas and their magnitudes
	assign dx    = {line.x2[W-1], line.x2} - {line.x1[W-1], line.x1};
	assign dy    = {line.y2[W-1], line.y2} - {line.y1[W-1], line.y1};
	assign mag_x = dx[W] ? -dx : dx;
	assign mag_y = dy[W] ? -dy : dy;

	// restoring divider, one quotient bit per cycle
	assign remt_x = {drx_q, dqx_q[W-1]};
	assign remt_y = {dry_q, dqy_q[W-1]};
	assign qb_x   = (remt_x >= {1'b0, n});
	assign qb_y   = (remt_y >= {1'b0, n});

	// remainder stepping per sample
	assign rsum_x = {1'b0, racx_q} + {1'b0, drx_q};
	assign rsum_y = {1'b0, racy_q} + {1'b0, dry_q};
	assign cy_x   = (rsum_x >= {1'b0, n});
	assign cy_y   = (rsum_y >= {1'b0, n});

	// interpolated point: p1 plus signed quotient
	assign offx = negx_q ? -$signed({1'b0, accx_q}) : $signed({1'b0, accx_q});
	assign offy = negy_q ? -$signed({1'b0, accy_q}) : $signed({1'b0, accy_q});
	assign sumx = {{2{p1x_q[W-1]}}, p1x_q} + {offx[W], offx};
	assign sumy = {{2{p1y_q[W-1]}}, p1y_q} + {offy[W], offy};

	// line registers: load, divide, step
	always_ff @(posedge clk) begin
		if (load) begin
			p1x_q  <= line.x1;
			p1y_q  <= line.y1;
			negx_q <= dx[W];
			negy_q <= dy[W];
			dqx_q  <= mag_x[W-1:0];
			dqy_q  <= mag_y[W-1:0];
			drx_q  <= '0;
			dry_q  <= '0;
			accx_q <= '0;
			accy_q <= '0;
			racx_q <= '0;
			racy_q <= '0;
		end else if (div_step) begin
			dqx_q <= {dqx_q[W-2:0], qb_x};
			dqy_q <= {dqy_q[W-2:0], qb_y};
			drx_q <= qb_x ? vls_pkg::CNT_W'(remt_x - {1'b0, n}) : remt_x[vls_pkg::CNT_W-1:0];
			dry_q <= qb_y ? vls_pkg::CNT_W'(remt_y - {1'b0, n}) : remt_y[vls_pkg::CNT_W-1:0];
		end else if (run_step) begin
			accx_q <= accx_q + dqx_q + W'(cy_x);
			accy_q <= accy_q + dqy_q + W'(cy_y);
			racx_q <= cy_x ? vls_pkg::CNT_W'(rsum_x - {1'b0, n})
			               : rsum_x[vls_pkg::CNT_W-1:0];
			racy_q <= cy_y ? vls_pkg::CNT_W'(rsum_y - {1'b0, n})
			               : rsum_y[vls_pkg::CNT_W-1:0];
		end
	end

	// divider and sample counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			step_q    <= '0;
		end else if (load) begin
			div_cnt_q <= '0;
			step_q    <= '0;
		end else begin
			if (div_step) begin
				div_cnt_q <= div_cnt_q + vls_pkg::DIV_CNT_W'(1);
			end
			if (run_step && !is_last) begin
				step_q <= step_q + vls_pkg::STEP_W'(1);
			end
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= run_step;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// pipeline payload: point, product, saturated sample
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1      <= sumx[W-1:0];
			vy_s1      <= sumy[W-1:0];
			last_s1    <= is_last;
			px_s2      <= vx_s1 * $signed({1'b0, cfg.scale_x});
			py_s2      <= vy_s1 * $signed({1'b0, cfg.scale_y});
			last_s2    <= last_s1;
			out_x_q    <= sat16(px_s2);
			out_y_q    <= sat16(py_s2);
			out_last_q <= last_s2;
		end
	end

	assign samples.valid       = out_valid_q;
	assign samples.scaled_x    = out_x_q;
	assign samples.scaled_y    = out_y_q;
	assign samples.last_sample = out_last_q;

	// sample counter stays inside the line while running
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vls_pkg::ST_RUN |-> {1'b0, step_q} < n)
		else $error("sample counter beyond line length");

	// a stalled pipeline keeps its samples
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s1 |=> v_s1)
		else $error("sample lost in a stalled pipeline");

	// a line is taken only when the sequencer is idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == vls_pkg::ST_IDLE && line_valid)
		else $error("line popped while busy");

	// the divider finishes straight into sampling
	a_div_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vls_pkg::ST_DIV &&
		div_cnt_q == vls_pkg::DIV_CNT_W'(vls_pkg::DIV_STEPS - 1)
		|=> state_q == vls_pkg::ST_RUN)
		else $error("divider did not hand over to sampling");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector line sampler: vertex writes and line
// draws go in over the item channel, and every sample that comes out is
// compared with a local prediction of the interpolation, scaling and
// saturation. Register settings change between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [vls_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int MAX_WAIT     = 18;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_LEN     = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int REPORT_CAP   = 100;

	// idling styles of the two sides
	localparam int IDLE_NONE  = 0;
	localparam int IDLE_LIGHT = 1;
	localparam int IDLE_HEAVY = 2;

	typedef struct packed {
		logic                               op;
		logic [vls_pkg::IDX_W-1:0]          vidx;
		logic signed [vls_pkg::COORD_W-1:0] vx;
		logic signed [vls_pkg::COORD_W-1:0] vy;
		logic [vls_pkg::IDX_W-1:0]          a;
		logic [vls_pkg::IDX_W-1:0]          b;
	} word_t;

	typedef struct packed {
		logic signed [vls_pkg::COORD_W-1:0] sx;
		logic signed [vls_pkg::COORD_W-1:0] sy;
		logic                               last;
	} sample_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [vls_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vls_pkg::SCALE_W-1:0]   cfg_data;

	vls_in_if  items_if ();
	vls_out_if samples_if ();

	vector_line_sampler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_if),
		.samples   (samples_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// stimulus and expectation stores
	word_t   word_backlog[$];
	sample_t due_samples[$];

	// predicted block state
	logic signed [vls_pkg::COORD_W-1:0] x_mem[vls_pkg::VERTEX_COUNT];
	logic signed [vls_pkg::COORD_W-1:0] y_mem[vls_pkg::VERTEX_COUNT];
	logic [vls_pkg::CNT_W-1:0]          cfg_samples;
	logic [vls_pkg::SCALE_W-1:0]        cfg_scale_x;
	logic [vls_pkg::SCALE_W-1:0]        cfg_scale_y;

	// generator bookkeeping: draws only touch slots already written
	bit slot_written[vls_pkg::VERTEX_COUNT];
	int written_slots[$];

	int send_mode;
	int recv_mode;
	int send_gap;
	int recv_wait;
	int hold_left;
	bit hold_done;
	int words_taken;
	int idle_cycles;
	int mismatches;
	int vertices_written;
	int lines_drawn;
	int samples_checked;
	int settings_used;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait(int mode);
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
			default:    return $urandom_range(0, MAX_WAIT);
		endcase
	endfunction

	// gain, arithmetic shift down by the fraction bits, clip to int16
	function automatic logic signed [vls_pkg::COORD_W-1:0] scale_clip(int v,
			logic [vls_pkg::SCALE_W-1:0] g);
		longint p;
		p = (longint'(v) * longint'(g)) >>> vls_pkg::FRAC_BITS;
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		return p[vls_pkg::COORD_W-1:0];
	endfunction

	// expected samples of one accepted word
	function automatic void trace_word(word_t w);
		int      n;
		int      i;
		int      x1;
		int      y1;
		int      dx;
		int      dy;
		sample_t s;
		if (w.op == vls_pkg::OP_WRITE) begin
			x_mem[w.vidx] = w.vx;
			y_mem[w.vidx] = w.vy;
			vertices_written++;
			return;
		end
		n = (cfg_samples == 0) ? 1 :
			(cfg_samples > vls_pkg::MAX_LINE_SAMPLES) ? vls_pkg::MAX_LINE_SAMPLES :
			int'(cfg_samples);
		x1 = x_mem[w.a];
		y1 = y_mem[w.a];
		dx = int'(x_mem[w.b]) - x1;
		dy = int'(y_mem[w.b]) - y1;
		for (i = 0; i < n; i++) begin
			s.sx   = scale_clip(x1 + (dx * i) / n, cfg_scale_x);
			s.sy   = scale_clip(y1 + (dy * i) / n, cfg_scale_y);
			s.last = (i == n - 1);
			due_samples.push_back(s);
		end
		lines_drawn++;
	endfunction

	function automatic logic signed [vls_pkg::COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return '0;
			default: return vls_pkg::COORD_W'($urandom);
		endcase
	endfunction

	// vertex write; the line fields ride along with random content
	function automatic void queue_write(int slot, logic signed [vls_pkg::COORD_W-1:0] x,
			logic signed [vls_pkg::COORD_W-1:0] y);
		word_t w;
		w.op   = vls_pkg::OP_WRITE;
		w.vidx = vls_pkg::IDX_W'(slot);
		w.vx   = x;
		w.vy   = y;
		w.a    = vls_pkg::IDX_W'($urandom);
		w.b    = vls_pkg::IDX_W'($urandom);
		if (!slot_written[slot]) begin
			slot_written[slot] = 1'b1;
			written_slots.push_back(slot);
		end
		word_backlog.push_back(w);
	endfunction

	// line draw; the vertex fields ride along with random content
	function automatic void queue_draw(int from_slot, int to_slot);
		word_t w;
		w.op   = vls_pkg::OP_DRAW;
		w.vidx = vls_pkg::IDX_W'($urandom);
		w.vx   = vls_pkg::COORD_W'($urandom);
		w.vy   = vls_pkg::COORD_W'($urandom);
		w.a    = vls_pkg::IDX_W'(from_slot);
		w.b    = vls_pkg::IDX_W'(to_slot);
		word_backlog.push_back(w);
	endfunction

	function automatic void queue_random_word();
		int a;
		int b;
		if (written_slots.size() < 2 || $urandom_range(0, 99) < 35) begin
			queue_write($urandom_range(0, vls_pkg::VERTEX_COUNT - 1), pick_coord(),
				pick_coord());
		end else begin
			a = written_slots[$urandom_range(0, written_slots.size() - 1)];
			b = ($urandom_range(0, 9) == 0) ? a :
				written_slots[$urandom_range(0, written_slots.size() - 1)];
			queue_draw(a, b);
		end
	endfunction

	// idle: all words in, all samples out, then let the back end settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (word_backlog.size() != 0 || items_if.valid || due_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// program all registers plus the unused index, one write per edge
	task automatic set_regs(int spl, logic [vls_pkg::SCALE_W-1:0] gx,
			logic [vls_pkg::SCALE_W-1:0] gy);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= vls_pkg::CFG_SAMPLES;
		cfg_data  <= {8'($urandom), 7'(spl)};
		@(posedge clk);
		cfg_index <= vls_pkg::CFG_SCALE_X;
		cfg_data  <= gx;
		@(posedge clk);
		cfg_index <= vls_pkg::CFG_SCALE_Y;
		cfg_data  <= gy;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= vls_pkg::SCALE_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_samples = vls_pkg::CNT_W'(spl);
		cfg_scale_x = gx;
		cfg_scale_y = gy;
		settings_used++;
	endtask

	task automatic run_phase(int spl, logic [vls_pkg::SCALE_W-1:0] gx,
			logic [vls_pkg::SCALE_W-1:0] gy, int words, int smode, int rmode);
		wait_idle();
		set_regs(spl, gx, gy);
		@(negedge clk);
		send_mode = smode;
		recv_mode = rmode;
		repeat (words) queue_random_word();
	endtask

	task automatic report_mismatch(string field, logic signed [16:0] want,
			logic signed [16:0] got);
		if (mismatches < REPORT_CAP)
			$error("%s: expected %0d, got %0d", field, want, got);
		mismatches++;
	endtask

	// word driver
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		int    gap;
		if (!arst_n) begin
			items_if.valid <= 1'b0;
			send_gap       <= 0;
			words_taken    <= 0;
		end else begin
			gap = send_gap;
			if (items_if.valid && items_if.ready) begin
				w.op   = items_if.operation;
				w.vidx = items_if.vertex_index;
				w.vx   = items_if.vertex_x;
				w.vy   = items_if.vertex_y;
				w.a    = items_if.start_index;
				w.b    = items_if.end_index;
				trace_word(w);
				words_taken <= words_taken + 1;
				// keep offering at full rate while the output is held off
				gap = (hold_left != 0) ? 0 : draw_wait(send_mode);
			end
			if (!items_if.valid || items_if.ready) begin
				if (gap != 0) begin
					items_if.valid <= 1'b0;
					send_gap       <= gap - 1;
				end else if (word_backlog.size() != 0) begin
					w = word_backlog.pop_front();
					items_if.valid        <= 1'b1;
					items_if.operation    <= w.op;
					items_if.vertex_index <= w.vidx;
					items_if.vertex_x     <= w.vx;
					items_if.vertex_y     <= w.vy;
					items_if.start_index  <= w.a;
					items_if.end_index    <= w.b;
					send_gap              <= 0;
				end else begin
					items_if.valid <= 1'b0;
					send_gap       <= 0;
				end
			end
		end
	end

	// sample monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		int      w;
		sample_t s;
		if (!arst_n) begin
			samples_if.ready <= 1'b0;
			recv_wait        <= 0;
		end else begin
			w = recv_wait;
			if (samples_if.valid && samples_if.ready) begin
				if (due_samples.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$error("sample word with nothing expected");
					mismatches++;
				end else begin
					s = due_samples.pop_front();
					if (samples_if.scaled_x !== s.sx)
						report_mismatch("scaled_x", s.sx, samples_if.scaled_x);
					if (samples_if.scaled_y !== s.sy)
						report_mismatch("scaled_y", s.sy, samples_if.scaled_y);
					if (samples_if.last_sample !== s.last)
						report_mismatch("last_sample", s.last, samples_if.last_sample);
				end
				samples_checked++;
				w = draw_wait(recv_mode);
			end
			if (hold_left != 0) begin
				samples_if.ready <= 1'b0;
				recv_wait        <= w;
			end else if (w != 0) begin
				samples_if.ready <= 1'b0;
				recv_wait        <= w - 1;
			end else begin
				samples_if.ready <= 1'b1;
			end
		end
	end

	// one long output hold-off, so the line queue fills and stalls the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && words_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((items_if.valid && items_if.ready) ||
				(samples_if.valid && samples_if.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// reset, directed lines, then random phases over several settings
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = vls_pkg::CFG_SAMPLES;
		cfg_data              = '0;
		items_if.valid        = 1'b0;
		items_if.operation    = vls_pkg::OP_WRITE;
		items_if.vertex_index = '0;
		items_if.vertex_x     = '0;
		items_if.vertex_y     = '0;
		items_if.start_index  = '0;
		items_if.end_index    = '0;
		samples_if.ready      = 1'b0;
		cfg_samples           = vls_pkg::SAMPLES_RESET;
		cfg_scale_x           = vls_pkg::SCALE_X_RESET;
		cfg_scale_y           = vls_pkg::SCALE_Y_RESET;
		send_mode             = IDLE_NONE;
		recv_mode             = IDLE_LIGHT;
		mismatches            = 0;
		vertices_written      = 0;
		lines_drawn           = 0;
		samples_checked       = 0;
		settings_used         = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: corner vertices, full swings, zero-length lines
		queue_write(0, 16'sh8000, 16'sh7fff);
		queue_write(vls_pkg::VERTEX_COUNT - 1, 16'sh7fff, 16'sh8000);
		queue_write(21, '0, '0);
		queue_write(42, pick_coord(), pick_coord());
		queue_draw(0, vls_pkg::VERTEX_COUNT - 1);
		queue_draw(vls_pkg::VERTEX_COUNT - 1, 0);
		queue_draw(21, 21);
		queue_draw(0, 0);
		queue_draw(42, 21);

		// single sample, count of zero, count above the maximum, zero gains
		run_phase(1, 15'h7fff, 15'h7fff, 40, IDLE_NONE, IDLE_NONE);
		run_phase(0, '0, '0, 25, IDLE_HEAVY, IDLE_LIGHT);
		run_phase(127, 15'h7fff, 15'd1, 30, IDLE_LIGHT, IDLE_HEAVY);
		run_phase(vls_pkg::MAX_LINE_SAMPLES, '0, 15'h7fff, 30, IDLE_LIGHT, IDLE_LIGHT);
		run_phase(2, vls_pkg::SCALE_W'($urandom), vls_pkg::SCALE_W'($urandom), 45,
			IDLE_LIGHT, IDLE_LIGHT);
		run_phase(5, vls_pkg::SCALE_W'($urandom), vls_pkg::SCALE_W'($urandom), 45,
			IDLE_HEAVY, IDLE_NONE);
		run_phase(13, vls_pkg::SCALE_W'($urandom), vls_pkg::SCALE_W'($urandom), 45,
			IDLE_NONE, IDLE_HEAVY);
		run_phase($urandom_range(1, vls_pkg::MAX_LINE_SAMPLES), vls_pkg::SCALE_W'($urandom),
			vls_pkg::SCALE_W'($urandom), 45, IDLE_HEAVY, IDLE_HEAVY);
		run_phase(3, vls_pkg::SCALE_X_RESET, vls_pkg::SCALE_Y_RESET, 45,
			IDLE_LIGHT, IDLE_NONE);
		wait_idle();

		if (due_samples.size() != 0) begin
			$error("%0d expected samples never arrived", due_samples.size());
			mismatches++;
		end
		$display("summary: %0d words in (%0d vertex writes, %0d lines), %0d samples out",
			words_taken, vertices_written, lines_drawn, samples_checked);
		$display("summary: %0d register settings incl. reset, one %0d-cycle output hold-off",
			settings_used + 1, HOLD_LEN);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> vector_line_sampler_unit.f
rtl/core/vls_pkg.sv
rtl/core/vls_in_if.sv
rtl/core/vls_out_if.sv
rtl/core/vls_front.sv
rtl/core/vls_queue.sv
rtl/core/vls_back.sv
rtl/core/vector_line_sampler_unit.sv
verif/tb_top.sv
